[sv/msda_pkg.sv]
// Shared constants, types and register codes of the multi-sensor distance alarm.
package msda_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int ADDR_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int DIST_W    = 16;
  localparam int SUM_W     = DIST_W + ((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 0);
  localparam int STEP_W    = $clog2(SUM_W + 1);
  localparam int SLOT_IN_W = 3;
  localparam int MODE_W    = 2;
  localparam int PERIOD_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int ACT_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SENSORS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_DISTANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DISTANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEAKER_ENABLED = 2'd3;

  localparam logic [DIST_W-1:0] BLINK_DIST_RST  = 16'd300;
  localparam logic [DIST_W-1:0] ACTIVE_DIST_RST = 16'd50;

  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd2;

  typedef struct packed {
    logic              known;
    logic [DIST_W-1:0] dist_mm;
  } slot_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/multi_sensor_distance_alarm_unit.sv]
// Top level of the multi-sensor distance alarm: slot store, averaging and tone selection.
// Each report is written into its slot, then the known distances of the active slots are
// read back from the slot memory one per cycle, summed, and divided by their count in a
// serial divider that yields one quotient bit per cycle (19 steps). The result reaches the
// output register after the write state, the slot read sweep, the divider and the finish
// state, and the block then returns to idle; a stalled output holds the finish state.
// One item is worked on at a time, and in_stall stays high from the accepted input until
// the finish state is left, which places its result in the output register unless
// speaker_enabled is zero.
// Writing active_sensors clears all slots to unknown at once; nothing is reported while
// speaker_enabled is zero, although the slots are still updated.
module multi_sensor_distance_alarm_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [msda_pkg::SLOT_IN_W-1:0]       in_sensor_slot,
  input  logic [msda_pkg::DIST_W-1:0]          in_distance_mm,
  input  logic                                 in_distance_known,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [msda_pkg::MODE_W-1:0]          out_tone_mode,
  output logic [msda_pkg::PERIOD_W-1:0]        out_blink_period,
  output logic [msda_pkg::DIST_W-1:0]          out_average_distance,
  input  logic                                 cfg_we,
  input  logic [msda_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [msda_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                          state_r, state_nxt;
  logic [msda_pkg::ACT_W-1:0]          active_r;
  logic [msda_pkg::DIST_W-1:0]         blink_dist_r;
  logic [msda_pkg::DIST_W-1:0]         active_dist_r;
  logic                                spk_en_r;
  logic [msda_pkg::SLOT_IN_W-1:0]      slot_r;
  logic [msda_pkg::DIST_W-1:0]         dist_r;
  logic                                known_r;
  logic [msda_pkg::MAX_SLOTS-1:0]      valid_r;
  logic [msda_pkg::CNT_W-1:0]          addr_r, addr_nxt;
  logic                                rd_pend_r, rd_pend_nxt;
  logic [msda_pkg::ADDR_W-1:0]         rd_slot_r;
  logic [msda_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic [msda_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                                out_valid_r;
  logic [msda_pkg::MODE_W-1:0]         mode_r;
  logic [msda_pkg::PERIOD_W-1:0]       period_r;
  logic [msda_pkg::DIST_W-1:0]         avg_r;

  logic [msda_pkg::CNT_W-1:0]          n_listen;
  logic                                in_acc;
  logic                                slot_live;
  logic                                ram_we;
  msda_pkg::slot_entry_t               ram_wdata;
  msda_pkg::slot_entry_t               ram_rdata;
  logic                                sum_done;
  logic                                div_start;
  logic [msda_pkg::SUM_W-1:0]          quotient;
  msda_pkg::div_stat_t                 div_stat;
  logic [msda_pkg::DIST_W-1:0]         avg_c;
  logic [msda_pkg::MODE_W-1:0]         mode_c;
  logic [msda_pkg::PERIOD_W-1:0]       period_c;
  logic                                fin_go;

  assign n_listen  = (active_r > msda_pkg::ACT_W'(msda_pkg::MAX_SLOTS))
                     ? msda_pkg::CNT_W'(msda_pkg::MAX_SLOTS)
                     : msda_pkg::CNT_W'(active_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_live = (msda_pkg::CNT_W'(slot_r) < n_listen);

  assign ram_we            = (state_r == S_WRITE) && slot_live;
  assign ram_wdata.known   = known_r;
  assign ram_wdata.dist_mm = known_r ? dist_r : '0;

  msda_slot_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (msda_pkg::ADDR_W'(slot_r)),
    .wdata   (ram_wdata),
    .raddr   (addr_r[msda_pkg::ADDR_W-1:0]),
    .rdata_r (ram_rdata)
  );

  assign sum_done  = (state_r == S_SUM) && (addr_r >= n_listen) && !rd_pend_r;
  assign div_start = sum_done;

  msda_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // The quotient can never exceed the largest single distance, so the low bits hold it.
  always_comb begin
    avg_c    = '0;
    mode_c   = msda_pkg::MODE_OFF;
    period_c = '0;
    if (cnt_r != '0) begin
      avg_c = quotient[msda_pkg::DIST_W-1:0];
      if (avg_c > blink_dist_r) begin
        mode_c = msda_pkg::MODE_OFF;
      end else if (avg_c > active_dist_r) begin
        mode_c   = msda_pkg::MODE_BLINK;
        period_c = avg_c[msda_pkg::DIST_W-1:1];
      end else begin
        mode_c = msda_pkg::MODE_ON;
      end
    end
  end

  assign fin_go = !spk_en_r || !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    rd_pend_nxt = 1'b0;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        addr_nxt  = '0;
        sum_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (addr_r < n_listen) begin
          addr_nxt    = addr_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
        // Slots whose valid bit is clear read as unknown since the last clear.
        if (rd_pend_r && valid_r[rd_slot_r] && ram_rdata.known) begin
          sum_nxt = sum_r + msda_pkg::SUM_W'(ram_rdata.dist_mm);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (sum_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_pend_r     <= 1'b0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      active_r      <= '0;
      blink_dist_r  <= msda_pkg::BLINK_DIST_RST;
      active_dist_r <= msda_pkg::ACTIVE_DIST_RST;
      spk_en_r      <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_we && (cfg_idx == msda_pkg::REG_ACTIVE_SENSORS)) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[msda_pkg::ADDR_W'(slot_r)] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_idx)
          msda_pkg::REG_ACTIVE_SENSORS:  active_r      <= cfg_wdata[msda_pkg::ACT_W-1:0];
          msda_pkg::REG_BLINK_DISTANCE:  blink_dist_r  <= cfg_wdata;
          msda_pkg::REG_ACTIVE_DISTANCE: active_dist_r <= cfg_wdata;
          msda_pkg::REG_SPEAKER_ENABLED: spk_en_r      <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if ((state_r == S_FIN) && spk_en_r && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r  <= in_sensor_slot;
      dist_r  <= in_distance_mm;
      known_r <= in_distance_known;
    end
    addr_r    <= addr_nxt;
    rd_slot_r <= addr_r[msda_pkg::ADDR_W-1:0];
    sum_r     <= sum_nxt;
    cnt_r     <= cnt_nxt;
    if ((state_r == S_FIN) && spk_en_r && fin_go) begin
      mode_r   <= mode_c;
      period_r <= period_c;
      avg_r    <= avg_c;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tone_mode        = mode_r;
  assign out_blink_period     = period_r;
  assign out_average_distance = avg_r;

  a_blink_period_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tone_mode == msda_pkg::MODE_BLINK)
      |-> out_blink_period == out_average_distance[msda_pkg::DIST_W-1:1])
    else $error("blink period does not match the average");

  a_off_no_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tone_mode != msda_pkg::MODE_BLINK) |-> out_blink_period == '0)
    else $error("blink period set outside blink mode");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_clear_on_count: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == msda_pkg::REG_ACTIVE_SENSORS) |=> valid_r == '0)
    else $error("slots not cleared after active count write");

endmodule

[sv/msda_slot_ram.sv]
// Slot memory: one write port, one read port with registered read data.
module msda_slot_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [msda_pkg::ADDR_W-1:0]  waddr,
  input  msda_pkg::slot_entry_t        wdata,
  input  logic [msda_pkg::ADDR_W-1:0]  raddr,
  output msda_pkg::slot_entry_t        rdata_r
);

  msda_pkg::slot_entry_t mem [msda_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

[sv/msda_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module msda_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msda_pkg::SUM_W-1:0]  dividend,
  input  logic [msda_pkg::CNT_W-1:0]  divisor,
  output logic [msda_pkg::SUM_W-1:0]  quotient,
  output msda_pkg::div_stat_t         stat
);

  logic [msda_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [msda_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [msda_pkg::CNT_W-1:0]  dvs_r;
  logic [msda_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [msda_pkg::CNT_W:0]    rem_sh;
  logic [msda_pkg::CNT_W:0]    diff;

  assign rem_sh = {rem_r, quo_r[msda_pkg::SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = msda_pkg::STEP_W'(msda_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // A borrow out of the trial subtraction means the divisor did not fit.
      if (!diff[msda_pkg::CNT_W]) begin
        rem_nxt = diff[msda_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[msda_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[msda_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[msda_pkg::SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == msda_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
